### rtl/nearest_centroid_classifier_defines.svh
// Assertion macros used by the nearest centroid classifier top level.
// Depends on nothing; the asserting modules provide clock and reset.
`ifndef NEAREST_CENTROID_CLASSIFIER_DEFINES_SVH
`define NEAREST_CENTROID_CLASSIFIER_DEFINES_SVH
`ifndef SYNTH
`define NCC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
`define NCC_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define NCC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define NCC_ASSERT(lbl, prop)
`define NCC_ASSERT_IMPL(lbl, ante, cons)
`define NCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/ncc_pkg.sv
// Types and constants of the nearest centroid classifier.
// Used by the lane, the merge stage and the top level; depends on nothing.
package ncc_pkg;

   localparam int COORD_W     = 16;
   localparam int MAX_DIMS    = 4;
   localparam int CLUSTER_W   = 4;
   localparam int DIST_W      = 34;
   localparam int SQ_W        = 32;
   localparam int CFG_W       = 5;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;

   localparam logic CMD_WRITE    = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [CLUSTER_W-1:0] index;
   } tag_type;

   typedef struct packed {
      logic                 valid;
      logic [CLUSTER_W-1:0] index;
      logic [DIST_W-1:0]    distance;
   } result_type;

endpackage

### rtl/ncc_lane.sv
// One coordinate lane: difference and square of observation and centroid.
// Depends on ncc_pkg; two register stages.
module ncc_lane
   import ncc_pkg::*;
(
   input  logic                      clock,
   input  logic signed [COORD_W-1:0] obs_coord,
   input  logic signed [COORD_W-1:0] cen_coord,
   output logic        [SQ_W-1:0]    lane_sq
);

   logic signed [COORD_W:0]     diff_ff;
   logic signed [COORD_W:0]     diff_in;
   logic        [SQ_W-1:0]      sq_ff;
   logic        [SQ_W-1:0]      sq_in;
   logic signed [2*COORD_W+1:0] prod;

   always_comb begin
      diff_in = {obs_coord[COORD_W-1], obs_coord} - {cen_coord[COORD_W-1], cen_coord};
      prod    = diff_ff * diff_ff;
      sq_in   = prod[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sq_ff   <= sq_in;
   end

   assign lane_sq = sq_ff;

endmodule

### rtl/ncc_merge.sv
// Merge stage: adds the lane squares and keeps the running minimum.
// Depends on ncc_pkg; fed by the ncc_lane instances and the tag pipeline.
module ncc_merge
   import ncc_pkg::*;
#(
   parameter int DIMS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  tag_type          tag,
   input  logic [SQ_W-1:0]  lane_sq [DIMS],
   output result_type       result
);

   logic [DIST_W-1:0]    sum_in;
   logic [DIST_W-1:0]    sum_ff;
   tag_type              tag_ff;
   logic [DIST_W-1:0]    best_ff;
   logic [DIST_W-1:0]    best_in;
   logic [CLUSTER_W-1:0] best_idx_ff;
   logic [CLUSTER_W-1:0] best_idx_in;
   logic                 take;
   result_type           res_ff;
   result_type           res_in;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < DIMS; i++) begin
         sum_in = sum_in + DIST_W'(lane_sq[i]);
      end
   end

   always_comb begin
      take        = (tag_ff.index == '0) || (sum_ff < best_ff);
      best_in     = take ? sum_ff : best_ff;
      best_idx_in = take ? tag_ff.index : best_idx_ff;
      res_in.valid    = tag_ff.valid && tag_ff.last;
      res_in.index    = best_idx_in;
      res_in.distance = best_in;
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (tag_ff.valid) begin
         best_ff     <= best_in;
         best_idx_ff <= best_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
         res_ff <= '0;
      end else begin
         tag_ff <= tag;
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

### rtl/nearest_centroid_classifier.sv
// Channel  Group              Payload
// req      req_tvalid/tready  tdata: cluster_index, coord_0..coord_3; tuser: command
// rsp      rsp_tvalid/tready  tdata: nearest_cluster, min_distance; tuser: is_classification
// csr      csr_wr_en          csr_wr_data: clusters_in_use
//
// A write is answered with an acknowledge; a classify steps through the clusters in use,
// with one centroid read per cycle from the centroid store.
// One item is in work at a time; a finished result may wait in the output register
// while the next item runs, and one more waits in a holding register.
// Reset clears control state only; the centroid store has no reset and no clearing pass.
// Top level of the nearest centroid classifier; uses ncc_pkg, ncc_lane and ncc_merge.
`include "nearest_centroid_classifier_defines.svh"
module nearest_centroid_classifier
   import ncc_pkg::*;
#(
   parameter int NUM_CLUSTERS = 16,
   parameter int DIMS         = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cluster_index [3:0], coord_0 [19:4], coord_1 [35:20], coord_2 [51:36],
   // coord_3 [67:52], zero fill [71:68]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // nearest_cluster [3:0], min_distance [37:4], zero fill [39:38]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // is_classification
   output logic                   rsp_tuser,
   input  logic                   csr_wr_en,
   input  logic [CFG_W-1:0]       csr_wr_data
);

   localparam int IDX_W = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
   localparam int WORD_W = MAX_DIMS * COORD_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [WORD_W-1:0]    store [NUM_CLUSTERS];
   logic [CFG_W-1:0]     cfg_count_ff;
   logic [CFG_W-1:0]     eff_count;
   logic [CFG_W-1:0]     last_idx;
   logic [1:0]           state_ff;
   logic [1:0]           state_in;
   logic [IDX_W-1:0]     cnt_ff;
   logic [IDX_W-1:0]     cnt_in;
   logic [WORD_W-1:0]    obs_ff;
   logic [WORD_W-1:0]    rd_data_ff;
   tag_type              issue_tag;
   tag_type              rd_tag_ff;
   tag_type              tag_d1_ff;
   tag_type              tag_d2_ff;
   result_type           merge_res;
   result_type           pend_ff;
   result_type           pend_in;
   logic                 pend_is_class_ff;
   logic                 pend_is_class_in;
   logic                 rsp_valid_ff;
   logic                 rsp_user_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                 req_xfer;
   logic                 rsp_load;
   logic                 slot_ok;
   logic [WORD_W-1:0]    req_word;
   logic [SQ_W-1:0]      lane_sq [DIMS];

   assign req_word   = req_tdata[CLUSTER_W +: WORD_W];
   assign req_tready = (state_ff == ST_IDLE) && !pend_ff.valid;
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_ok    = {1'b0, req_tdata[CLUSTER_W-1:0]} < CFG_W'(NUM_CLUSTERS);
   assign rsp_load   = pend_ff.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (cfg_count_ff == '0) begin
         eff_count = CFG_W'(1);
      end else if (cfg_count_ff > CFG_W'(NUM_CLUSTERS)) begin
         eff_count = CFG_W'(NUM_CLUSTERS);
      end else begin
         eff_count = cfg_count_ff;
      end
      last_idx = eff_count - CFG_W'(1);
   end

   always_comb begin
      issue_tag.valid = (state_ff == ST_RUN);
      issue_tag.last  = (cnt_ff == last_idx[IDX_W-1:0]);
      issue_tag.index = CLUSTER_W'(cnt_ff);
   end

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      pend_in          = pend_ff;
      pend_is_class_in = pend_is_class_ff;
      if (rsp_load) begin
         pend_in.valid = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_xfer) begin
               if (req_tuser == CMD_CLASSIFY) begin
                  state_in = ST_RUN;
               end else begin
                  pend_in.valid    = 1'b1;
                  pend_in.index    = '0;
                  pend_in.distance = '0;
                  pend_is_class_in = 1'b0;
               end
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (issue_tag.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (merge_res.valid) begin
               pend_in          = merge_res;
               pend_is_class_in = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_xfer && (req_tuser == CMD_WRITE) && slot_ok) begin
         store[req_tdata[IDX_W-1:0]] <= req_word;
      end
      rd_data_ff <= store[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         obs_ff <= req_word;
      end
      cnt_ff           <= cnt_in;
      pend_is_class_ff <= pend_is_class_in;
      if (rsp_load) begin
         rsp_user_ff <= pend_is_class_ff;
         rsp_data_ff <= RSP_TDATA_W'({pend_ff.distance, pend_ff.index});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_count_ff  <= CFG_W'(16);
         rd_tag_ff     <= '0;
         tag_d1_ff     <= '0;
         tag_d2_ff     <= '0;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            cfg_count_ff <= csr_wr_data;
         end
         rd_tag_ff     <= issue_tag;
         tag_d1_ff     <= rd_tag_ff;
         tag_d2_ff     <= tag_d1_ff;
         pend_ff       <= pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   for (genvar d = 0; d < DIMS; d++) begin : g_lane
      ncc_lane u_lane (
         .clock     (clock),
         .obs_coord (obs_ff[d*COORD_W +: COORD_W]),
         .cen_coord (rd_data_ff[d*COORD_W +: COORD_W]),
         .lane_sq   (lane_sq[d])
      );
   end

   ncc_merge #(
      .DIMS (DIMS)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .tag     (tag_d2_ff),
      .lane_sq (lane_sq),
      .result  (merge_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   `NCC_ASSERT_IMPL(a_merge_only_in_drain, merge_res.valid, state_ff == ST_DRAIN)
   `NCC_ASSERT_NEXT(a_pend_held, pend_ff.valid && !rsp_load, pend_ff.valid)
   `NCC_ASSERT_IMPL(a_ack_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `NCC_ASSERT_IMPL(a_class_in_range, rsp_tvalid && rsp_tuser,
                    {1'b0, rsp_tdata[CLUSTER_W-1:0]} < eff_count)

endmodule

### tb/sv/nearest_centroid_classifier_test.sv
// Self-checking test of the nearest centroid classifier: centroid writes and classify
// transfers, random handshake gaps, and several settings of clusters_in_use.
// Depends on ncc_pkg and the nearest_centroid_classifier RTL.
module nearest_centroid_classifier_test
   import ncc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CLUSTERS = 16;
   localparam int DIMS         = 4;
   localparam int RANDOM_PHASE_ITEMS = 90;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;

   typedef logic [MAX_DIMS-1:0][COORD_W-1:0] point_type;

   typedef struct packed {
      logic                 command;
      logic [CLUSTER_W-1:0] slot;
      point_type            coord;
   } request_type;

   typedef struct packed {
      logic                 is_class;
      logic [CLUSTER_W-1:0] cluster;
      logic [DIST_W-1:0]    distance;
   } assignment_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en = 1'b0;
   logic [CFG_W-1:0]       csr_wr_data = '0;

   request_type    pending_requests[$];
   assignment_type expected_assignments[$];
   point_type      centroid_mem[NUM_CLUSTERS];
   point_type      planned_mem[NUM_CLUSTERS];
   logic [CFG_W-1:0] cfg_clusters = CFG_W'(16);
   request_type    offered;
   assignment_type got, want;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned failures = 0;
   int unsigned writes_done = 0;
   int unsigned classes_done = 0;
   int unsigned settings_done = 0;

   nearest_centroid_classifier #(
      .NUM_CLUSTERS(NUM_CLUSTERS),
      .DIMS        (DIMS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic assignment_type predict_assignment(request_type r);
      assignment_type a;
      int unsigned count;
      longint diff;
      longint unsigned sq_sum, best;
      a = '0;
      if (r.command == CMD_WRITE) begin
         centroid_mem[r.slot] = r.coord;
         return a;
      end
      count = (cfg_clusters == 0) ? 1 :
              (cfg_clusters > NUM_CLUSTERS) ? NUM_CLUSTERS : cfg_clusters;
      a.is_class = 1'b1;
      best = 0;
      for (int k = 0; k < count; k++) begin
         sq_sum = 0;
         for (int d = 0; d < DIMS; d++) begin
            diff = longint'($signed(centroid_mem[k][d])) - longint'($signed(r.coord[d]));
            sq_sum += longint'(diff * diff);
         end
         if (k == 0 || sq_sum < best) begin
            best = sq_sum;
            a.cluster = CLUSTER_W'(k);
         end
      end
      a.distance = best[DIST_W-1:0];
      return a;
   endfunction

   function automatic point_type random_point();
      point_type p;
      logic [COORD_W-1:0] pool[4] = '{16'h1234, 16'hF000, 16'h0100, 16'hFF80};
      for (int d = 0; d < MAX_DIMS; d++) begin
         case ($urandom_range(9))
            0: p[d] = 16'h8000;
            1: p[d] = 16'h7FFF;
            2: p[d] = '0;
            3: p[d] = pool[$urandom_range(3)];
            default: p[d] = COORD_W'($urandom);
         endcase
      end
      return p;
   endfunction

   function automatic point_type random_observation();
      point_type p;
      int unsigned k;
      int unsigned pick;
      k = $urandom_range(NUM_CLUSTERS - 1);
      pick = $urandom_range(9);
      p = random_point();
      if (pick < 2) begin
         p = planned_mem[k];
      end else if (pick < 6) begin
         for (int d = 0; d < MAX_DIMS; d++)
            p[d] = planned_mem[k][d] + COORD_W'($urandom_range(64)) - COORD_W'(32);
      end
      return p;
   endfunction

   task automatic queue_request(logic command, logic [CLUSTER_W-1:0] slot, point_type coord);
      request_type r;
      r.command = command;
      r.slot    = slot;
      r.coord   = coord;
      if (command == CMD_WRITE)
         planned_mem[slot] = coord;
      pending_requests = {pending_requests, r};
   endtask

   task automatic settle();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_assignments.size() != 0);
   endtask

   task automatic write_clusters_in_use(logic [CFG_W-1:0] value);
      settle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cfg_clusters = value;
      settings_done++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Request driver: the accepted transfer updates the prediction, then the next item is offered.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_assignments = {expected_assignments, predict_assignment(offered)};
            if (offered.command == CMD_WRITE)
               writes_done++;
            else
               classes_done++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {offered.coord, offered.slot};
               req_tuser  <= offered.command;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.is_class = rsp_tuser;
            got.cluster  = rsp_tdata[CLUSTER_W-1:0];
            got.distance = rsp_tdata[CLUSTER_W +: DIST_W];
            if (expected_assignments.size() == 0) begin
               $error("result transfer with no result expected");
               failures++;
            end else begin
               want = expected_assignments.pop_front();
               if (got.is_class !== want.is_class) begin
                  $error("is_classification: expected %0d, got %0d", want.is_class, got.is_class);
                  failures++;
               end
               if (got.cluster !== want.cluster) begin
                  $error("nearest_cluster: expected %0d, got %0d", want.cluster, got.cluster);
                  failures++;
               end
               if (got.distance !== want.distance) begin
                  $error("min_distance: expected %0d, got %0d", want.distance, got.distance);
                  failures++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("nearest_centroid_classifier_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [CFG_W-1:0] phase_cfg[12];
      point_type p;
      phase_cfg = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd5, 5'd8, 5'd15, 5'd17, 5'd3, 5'd12,
                    5'd16};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 27;
      recv_idle_pct = 70;

      // Fill every slot first; slots 0 and 1 are equal so that ties resolve to the lower one.
      for (int s = 0; s < NUM_CLUSTERS; s++) begin
         if (s < 2)
            p = {MAX_DIMS{16'h7FFF}};
         else if (s == 2)
            p = {MAX_DIMS{16'h8000}};
         else if (s == 3)
            p = {16'h0000, 16'h0000, 16'hFFFF, 16'h0001};
         else
            p = random_point();
         queue_request(CMD_WRITE, CLUSTER_W'(s), p);
      end
      queue_request(CMD_CLASSIFY, CLUSTER_W'($urandom), {MAX_DIMS{16'h8000}});
      queue_request(CMD_CLASSIFY, CLUSTER_W'($urandom), {MAX_DIMS{16'h7FFF}});
      queue_request(CMD_CLASSIFY, CLUSTER_W'($urandom), '0);
      queue_request(CMD_CLASSIFY, CLUSTER_W'($urandom), random_point());
      write_clusters_in_use(CFG_W'(1));
      queue_request(CMD_CLASSIFY, CLUSTER_W'($urandom), {MAX_DIMS{16'h8000}});
      queue_request(CMD_CLASSIFY, CLUSTER_W'($urandom), random_point());
      write_clusters_in_use(CFG_W'(0));
      queue_request(CMD_CLASSIFY, CLUSTER_W'($urandom), random_point());
      write_clusters_in_use(CFG_W'(31));
      queue_request(CMD_CLASSIFY, CLUSTER_W'($urandom), {MAX_DIMS{16'h8000}});

      for (int ph = 0; ph < 12; ph++) begin
         write_clusters_in_use(phase_cfg[ph]);
         if (ph == 4) begin
            send_idle_pct = 70;
            recv_idle_pct = 27;
         end else if (ph == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < RANDOM_PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 15)
               queue_request(CMD_WRITE, CLUSTER_W'($urandom), random_point());
            else
               queue_request(CMD_CLASSIFY, CLUSTER_W'($urandom), random_observation());
         end
         if (ph == 2 || ph == 9)
            hold_requests++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_assignments.size() != 0) begin
         $error("%0d results never arrived", expected_assignments.size());
         failures++;
      end
      $display("Covered %0d centroid writes and %0d classifications over %0d settings",
               writes_done, classes_done, settings_done);
      $display("of clusters_in_use, including 0 and 31, with long result back-pressure.");
      if (failures == 0) begin
         $display("nearest_centroid_classifier_test passed");
      end else begin
         $display("nearest_centroid_classifier_test failed");
      end
      $finish;
   end

endmodule
